// ===== hw/rtl/assert_macros.svh =====
// assertion helpers, all sampled on the rising clock edge and off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define ASSERT_SAME(label, ante, cons, msg) \
   `ASSERT_CLK(label, (ante) |-> (cons), msg)

`define ASSERT_NEXT(label, ante, cons, msg) \
   `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

// ===== hw/rtl/gpns_pkg.sv =====
package gpns_pkg;

   localparam int TERMS_DEFAULT = 12;

   localparam int LCG_W  = 48;
   localparam int DATA_W = 32;

   localparam logic [34:0]      LCG_MUL = 35'h5DEECE66D;
   localparam logic [LCG_W-1:0] LCG_INC = 48'hB;
   localparam logic [15:0]      LCG_LOW = 16'h330E;

   typedef logic [1:0] axis_type;

   localparam axis_type AXIS_X     = 2'd0;
   localparam axis_type AXIS_Y     = 2'd1;
   localparam axis_type AXIS_THETA = 2'd2;
   localparam axis_type AXIS_NONE  = 2'd3;

   typedef struct packed {
      logic     load;
      logic     step_lo;
      logic     step_hi;
      logic     prod_en;
      logic     acc_en;
      logic     clr_sum;
      logic     fin_en;
      logic     sat_en;
      logic     pass_en;
      logic     out_load;
      axis_type axis;
   } cmd_type;

   typedef struct packed {
      logic bad;
      logic sigma_zero;
   } status_type;

endpackage

// ===== hw/rtl/gpns_ctrl.sv =====
`include "assert_macros.svh"

module gpns_ctrl
   import gpns_pkg::*;
#(
   parameter int TERMS = TERMS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int K_W = (TERMS > 1) ? $clog2(TERMS) : 1;
   localparam logic [K_W-1:0] K_LAST = K_W'(TERMS - 1);

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_CHECK = 10'b00_0000_0010,
      ST_SETUP = 10'b00_0000_0100,
      ST_LO    = 10'b00_0000_1000,
      ST_HI    = 10'b00_0001_0000,
      ST_PROD  = 10'b00_0010_0000,
      ST_ACC   = 10'b00_0100_0000,
      ST_FIN   = 10'b00_1000_0000,
      ST_SAT   = 10'b01_0000_0000,
      ST_DONE  = 10'b10_0000_0000
   } state_type;

   state_type      state_ff, state_in;
   logic [K_W-1:0] k_ff, k_in;
   axis_type       axis_ff, axis_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      axis_in  = axis_ff;
      cmd      = '0;
      cmd.axis = axis_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               axis_in  = AXIS_X;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = status.bad ? ST_DONE : ST_SETUP;
         end
         ST_SETUP: begin
            if (status.sigma_zero) begin
               // zero spread: mean passes through, generator untouched
               cmd.pass_en = 1'b1;
               if (axis_ff == AXIS_THETA) begin
                  state_in = ST_DONE;
               end else begin
                  axis_in = axis_ff + 2'd1;
               end
            end else begin
               cmd.clr_sum = 1'b1;
               k_in        = '0;
               state_in    = ST_LO;
            end
         end
         ST_LO: begin
            cmd.step_lo = 1'b1;
            // product of the previous draw overlaps this step
            cmd.prod_en = (k_ff != '0);
            state_in    = ST_HI;
         end
         ST_HI: begin
            cmd.step_hi = 1'b1;
            cmd.acc_en  = (k_ff != '0);
            if (k_ff == K_LAST) begin
               state_in = ST_PROD;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_LO;
            end
         end
         ST_PROD: begin
            cmd.prod_en = 1'b1;
            state_in    = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_en = 1'b1;
            state_in   = ST_FIN;
         end
         ST_FIN: begin
            cmd.fin_en = 1'b1;
            state_in   = ST_SAT;
         end
         ST_SAT: begin
            cmd.sat_en = 1'b1;
            if (axis_ff == AXIS_THETA) begin
               state_in = ST_DONE;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_SETUP;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         axis_ff      <= AXIS_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   `ASSERT_SAME(a_term_count_range, (state_ff == ST_LO || state_ff == ST_HI), k_ff <= K_LAST,
      "term counter ran past the last term")
   `ASSERT_SAME(a_axis_valid, (state_ff == ST_SETUP || state_ff == ST_SAT), axis_ff != AXIS_NONE,
      "axis select out of range while drawing")
   `ASSERT_NEXT(a_done_after_load, cmd.out_load, rsp_tvalid && state_ff == ST_IDLE,
      "result load did not leave a valid result and an idle controller")

endmodule

// ===== hw/rtl/gpns_datapath.sv =====
`include "assert_macros.svh"

module gpns_datapath
   import gpns_pkg::*;
#(
   parameter int TERMS = TERMS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [DATA_W-1:0]  csr_wr_data,
   input  logic [159:0]       req_tdata,
   input  cmd_type            cmd,
   output status_type         status,
   output logic [95:0]        rsp_tdata,
   output logic               rsp_tuser
);

   // sum of floored products stays below TERMS * 2^31
   localparam int SUM_W = 31 + $clog2(TERMS + 1);

   logic signed [DATA_W-1:0] mx_ff, my_ff, mt_ff, st_ff, sr_ff;
   logic                     bad_ff;

   logic [LCG_W-1:0] lcg_ff, lcg_in;
   logic [LCG_W-1:0] lo_ff;
   logic [62:0]      prod_ff;
   logic [SUM_W-1:0] sum_ff;
   logic signed [SUM_W:0] half_ff;

   logic [DATA_W-1:0] rx_ff, ry_ff, rt_ff;
   logic [95:0]       rsp_data_ff;
   logic              rsp_bad_ff;

   logic [DATA_W-1:0] mean_sel, sigma_sel;
   logic [58:0]       lo_full;
   logic [47:0]       hi_full;
   logic [62:0]       prod_full;
   logic [SUM_W-1:0]  ts;
   logic signed [SUM_W+1:0] diff;
   logic signed [SUM_W+1:0] total;
   logic [SUM_W-30:0]       top_bits;
   logic [DATA_W-1:0]       sat_val;

   always_comb begin
      unique case (cmd.axis)
         AXIS_X: begin
            mean_sel  = mx_ff;
            sigma_sel = st_ff;
         end
         AXIS_Y: begin
            mean_sel  = my_ff;
            sigma_sel = st_ff;
         end
         AXIS_THETA: begin
            mean_sel  = mt_ff;
            sigma_sel = sr_ff;
         end
         default: begin
            mean_sel  = mx_ff;
            sigma_sel = st_ff;
         end
      endcase
   end

   // generator step in two parts: low half times full multiplier, then the
   // high half's contribution, which only reaches the upper 24 bits
   assign lo_full = lcg_ff[23:0] * LCG_MUL;
   assign hi_full = lcg_ff[47:24] * LCG_MUL[23:0];

   always_comb begin
      lcg_in = lcg_ff;
      if (csr_wr_en) begin
         lcg_in = {csr_wr_data, LCG_LOW};
      end else if (cmd.step_hi) begin
         lcg_in = lo_ff + {hi_full[23:0], 24'd0} + LCG_INC;
      end
   end

   assign prod_full = lcg_ff[47:16] * sigma_sel[30:0];

   assign ts   = SUM_W'(TERMS) * SUM_W'(sigma_sel[30:0]);
   assign diff = $signed({1'b0, sum_ff, 1'b0}) - $signed({2'b00, ts});

   assign total = $signed({{(SUM_W-30){mean_sel[31]}}, mean_sel})
                + $signed({half_ff[SUM_W], half_ff});

   assign top_bits = total[SUM_W+1:31];

   always_comb begin
      if (&top_bits || ~|top_bits) begin
         sat_val = total[31:0];
      end else if (total[SUM_W+1]) begin
         sat_val = 32'h8000_0000;
      end else begin
         sat_val = 32'h7FFF_FFFF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lcg_ff <= {32'd0, LCG_LOW};
      end else begin
         lcg_ff <= lcg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mx_ff  <= req_tdata[31:0];
         my_ff  <= req_tdata[63:32];
         mt_ff  <= req_tdata[95:64];
         st_ff  <= req_tdata[127:96];
         sr_ff  <= req_tdata[159:128];
         bad_ff <= req_tdata[127] | req_tdata[159];
      end
      if (cmd.step_lo) begin
         lo_ff <= lo_full[47:0];
      end
      if (cmd.prod_en) begin
         prod_ff <= prod_full;
      end
      if (cmd.clr_sum) begin
         sum_ff <= '0;
      end else if (cmd.acc_en) begin
         sum_ff <= sum_ff + SUM_W'(prod_ff[62:32]);
      end
      if (cmd.fin_en) begin
         // floor of the offset divided by two
         half_ff <= diff[SUM_W+1:1];
      end
      if (cmd.sat_en || cmd.pass_en) begin
         unique case (cmd.axis)
            AXIS_X:     rx_ff <= cmd.pass_en ? mean_sel : sat_val;
            AXIS_Y:     ry_ff <= cmd.pass_en ? mean_sel : sat_val;
            AXIS_THETA: rt_ff <= cmd.pass_en ? mean_sel : sat_val;
            default: begin
            end
         endcase
      end
      if (cmd.out_load) begin
         rsp_data_ff <= bad_ff ? 96'd0 : {rt_ff, ry_ff, rx_ff};
         rsp_bad_ff  <= bad_ff;
      end
   end

   assign status.bad        = bad_ff;
   assign status.sigma_zero = (sigma_sel == '0);

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_bad_ff;

   `ASSERT_NEXT(a_seed_low_bits, csr_wr_en, lcg_ff[15:0] == LCG_LOW,
      "seed write did not set the fixed low generator bits")

endmodule

// ===== hw/rtl/gaussian_pose_noise_sampler.sv =====
// after the input transfer the spread check runs, then each axis takes TERMS generator steps and
// a last product, sum, halving and saturation; an axis with zero spread passes its mean through,
// a negative spread goes straight to the result; a new pose is taken only once the last result
// is loaded; each generator step has two halves since the 48-bit state product is split in two
// reset: synchronous, active high; generator returns to seed 0, channels come up idle
module gaussian_pose_noise_sampler
   import gpns_pkg::*;
#(
   parameter int TERMS = TERMS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [DATA_W-1:0]   csr_wr_data,
   input  logic                req_tvalid,
   output logic                req_tready,
   // mean_x, mean_y, mean_theta, sigma_trans, sigma_rot
   input  logic [159:0]        req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // sample_x, sample_y, sample_theta
   output logic [95:0]         rsp_tdata,
   // bad_spread
   output logic                rsp_tuser
);

   cmd_type    cmd;
   status_type status;

   gpns_ctrl #(
      .TERMS (TERMS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gpns_datapath #(
      .TERMS (TERMS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .cmd         (cmd),
      .status      (status),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

// ===== tb/sv/gaussian_pose_noise_sampler_tb.sv =====
`timescale 1ns / 1ps

module gaussian_pose_noise_sampler_tb
   import gpns_pkg::*;
();

   localparam int          TERMS       = TERMS_DEFAULT;
   localparam logic [63:0] LCG_A       = 64'h5_DEEC_E66D;
   localparam logic [63:0] LCG_C       = 64'hB;
   localparam logic [15:0] SEED_TAIL   = 16'h330E;
   localparam int          STALL_LIMIT = 1000;
   localparam int          TAIL_CYCLES = 100;

   typedef struct {
      logic signed [31:0] mean_x;
      logic signed [31:0] mean_y;
      logic signed [31:0] mean_theta;
      logic signed [31:0] sigma_trans;
      logic signed [31:0] sigma_rot;
   } pose_req_type;

   typedef struct {
      logic signed [31:0] sample_x;
      logic signed [31:0] sample_y;
      logic signed [31:0] sample_theta;
      logic               bad_spread;
   } pose_rsp_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              csr_wr_en   = 1'b0;
   logic [DATA_W-1:0] csr_wr_data = '0;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [159:0]      req_tdata   = '0;
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [95:0]       rsp_tdata;
   logic              rsp_tuser;

   // model copy of the 48-bit generator
   logic [47:0]  noise_lcg = {32'd0, SEED_TAIL};
   pose_rsp_type pose_expected[$];
   int           error_count   = 0;
   int           quiet_cycles  = 0;
   int           stall_left    = 0;
   bit           req_gaps_on   = 1'b0;
   bit           rsp_stalls_on = 1'b0;

   gaussian_pose_noise_sampler i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always #2 clock = ~clock;

   function automatic logic signed [31:0] draw_axis(input logic signed [31:0] mean,
                                                    input logic signed [31:0] sigma);
      longint    sum;
      longint    total;
      bit [63:0] nxt;
      bit [63:0] prod;
      int        k;
      sum = 0;
      if (sigma == 0)
         return mean;
      for (k = 0; k < TERMS; k++) begin
         nxt       = {16'd0, noise_lcg} * LCG_A + LCG_C;
         noise_lcg = nxt[47:0];
         prod      = {32'd0, noise_lcg[47:16]} * {32'd0, sigma};
         sum       += longint'(prod >> 32);
      end
      // arithmetic shift gives the floor of the halved offset
      total = longint'(mean) + ((2 * sum - longint'(TERMS) * longint'(sigma)) >>> 1);
      if (total > 64'sd2147483647)
         total = 64'sd2147483647;
      if (total < -64'sd2147483648)
         total = -64'sd2147483648;
      return total[31:0];
   endfunction

   function automatic pose_rsp_type predict_pose(input pose_req_type p);
      pose_rsp_type r;
      r = '{default: 0};
      if (p.sigma_trans < 0 || p.sigma_rot < 0) begin
         r.bad_spread = 1'b1;
         return r;
      end
      r.sample_x     = draw_axis(p.mean_x, p.sigma_trans);
      r.sample_y     = draw_axis(p.mean_y, p.sigma_trans);
      r.sample_theta = draw_axis(p.mean_theta, p.sigma_rot);
      return r;
   endfunction

   function automatic pose_req_type make_pose(input logic [31:0] mx, input logic [31:0] my,
                                              input logic [31:0] mt, input logic [31:0] st,
                                              input logic [31:0] sr);
      pose_req_type p;
      p.mean_x      = mx;
      p.mean_y      = my;
      p.mean_theta  = mt;
      p.sigma_trans = st;
      p.sigma_rot   = sr;
      return p;
   endfunction

   function automatic logic [31:0] rand_mean();
      logic [31:0] v;
      v = $urandom();
      case ($urandom_range(0, 9))
         0: v = 32'h7FFF_FFFF - $urandom_range(0, 32'h0010_0000);
         1: v = 32'h8000_0000 + $urandom_range(0, 32'h0010_0000);
         // within about +-8.0
         2, 3, 4: v = {{12{v[31]}}, v[19:0]};
         default: ;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] rand_spread();
      logic [31:0] v;
      v = $urandom();
      case ($urandom_range(0, 19))
         0: v = '0;
         1: v[31] = 1'b1;
         2, 3, 4: v[31] = 1'b0;
         default: v = $urandom_range(1, 32'h0008_0000);
      endcase
      return v;
   endfunction

   function automatic pose_req_type rand_pose();
      return make_pose(rand_mean(), rand_mean(), rand_mean(), rand_spread(), rand_spread());
   endfunction

   task automatic send_pose(input pose_req_type p);
      if (req_gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {p.sigma_rot, p.sigma_trans, p.mean_theta, p.mean_y, p.mean_x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pose_expected.push_back(predict_pose(p));
   endtask

   task automatic drain_poses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pose_expected.size() != 0) @(posedge clock);
   endtask

   // keep_en holds the write enable high for a following write
   task automatic write_seed(input logic [31:0] s, input bit keep_en = 1'b0);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= s;
      @(posedge clock);
      if (!keep_en)
         csr_wr_en <= 1'b0;
      noise_lcg = {s, SEED_TAIL};
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   // corners run from the reset seed
   task automatic test_spread_corners();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b1;
      send_pose(make_pose(32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
      send_pose(make_pose(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0));
      send_pose(make_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_pose(make_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_pose(make_pose(32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h1, 32'h1));
      send_pose(make_pose(32'h1234_5678, 32'h9ABC_DEF0, 32'h0003_2440, 32'h0, 32'h0001_0000));
      send_pose(make_pose(32'hFFF0_0000, 32'h000F_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0));
      send_pose(make_pose(32'h0005_0000, 32'h0006_0000, 32'h0007_0000, 32'hFFFF_FFFF, 32'h1));
      send_pose(make_pose(32'h0005_0000, 32'h0006_0000, 32'h0007_0000, 32'h1, 32'h8000_0000));
      send_pose(make_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h8000_0000));
      send_pose(make_pose(32'h0, 32'h0, 32'h0, 32'hC000_0000, 32'h0));
      send_pose(make_pose(32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 32'h0002_0000, 32'h0000_C000));
      send_pose(make_pose(32'h0, 32'h0, 32'h7FFF_0000, 32'h0, 32'h7FFF_FFFF));
      send_pose(make_pose(32'h0, 32'h0, 32'h8001_0000, 32'h0, 32'h7FFF_FFFF));
      drain_poses();
   endtask

   task automatic test_seed_writes();
      write_seed(32'hFFFF_FFFF);
      repeat (4) send_pose(make_pose(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0000_8000));
      drain_poses();
      // back-to-back writes, the second must win
      write_seed(32'h0, 1'b1);
      write_seed(32'h8000_0000);
      repeat (4) send_pose(rand_pose());
      drain_poses();
      write_seed(32'h0);
      repeat (3) send_pose(make_pose(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0000_8000));
      drain_poses();
   endtask

   task automatic test_random_poses();
      repeat (6) begin
         write_seed($urandom());
         req_gaps_on   = $urandom_range(0, 3) != 0;
         rsp_stalls_on = $urandom_range(0, 3) != 0;
         repeat (100) send_pose(rand_pose());
         drain_poses();
      end
   endtask

   task automatic test_steady_stream();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      write_seed($urandom());
      repeat (160) send_pose(rand_pose());
      drain_poses();
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_stalls_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 14) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      pose_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pose_expected.size() == 0) begin
            $display("%0t: result with none expected, expected nothing, actual %h %b",
                     $time, rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            want = pose_expected.pop_front();
            check_field("sample_x", want.sample_x, rsp_tdata[31:0]);
            check_field("sample_y", want.sample_y, rsp_tdata[63:32]);
            check_field("sample_theta", want.sample_theta, rsp_tdata[95:64]);
            check_field("bad_spread", {31'd0, want.bad_spread}, {31'd0, rsp_tuser});
         end
      end
   end

   // counts cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         quiet_cycles = 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("%0t: timeout", $time);
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles++;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_spread_corners();
      test_seed_writes();
      test_random_poses();
      test_steady_stream();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pose_expected.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
